// File: hdl/rai_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rai_pkg
// shared types and constants of the resource allocation ie parser
// ----------------------------------------------------------------------------
package rai_pkg;

    // kind of a decoded field
    typedef enum logic [3:0] {
        KIND_HEADER   = 4'd0,
        KIND_DL_START = 4'd1,
        KIND_DL_LEN   = 4'd2,
        KIND_UL_START = 4'd3,
        KIND_UL_LEN   = 4'd4,
        KIND_SHORT_ID = 4'd5,
        KIND_REP      = 4'd6,
        KIND_VALIDITY = 4'd7,
        KIND_SFN      = 4'd8,
        KIND_CHANNEL  = 4'd9,
        KIND_FAILURE  = 4'd10
    } t_field_kind;

    // per-item status
    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_RESERVED = 2'd1,
        STAT_INVALID  = 2'd2
    } t_status;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_WIDE_SUBSLOT = 2'd0,
        REG_CHANNEL_MIN  = 2'd1,
        REG_CHANNEL_MAX  = 2'd2
    } t_reg_idx;

    localparam int          CHANNEL_W       = 13;
    localparam int          FAILURE_W       = 4;
    localparam logic [2:0]  REPEAT_MAX      = 3'd4;
    localparam logic [3:0]  PHASE_IDLE      = 4'd0;
    localparam logic [3:0]  PHASE_SECOND    = 4'd1;
    localparam logic [3:0]  PHASE_FIRST_FLD = 4'd2;
    localparam logic [3:0]  PHASE_LAST_FLD  = 4'd11;
    localparam int          OUT_TDATA_W     = 24;

    // tdata bit positions of the result channel
    localparam int          OUT_STATUS_LSB  = 16;

endpackage

// File: hdl/resource_allocation_ie_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resource_allocation_ie_parser
// octet-serial parser of a resource allocation information element
// ----------------------------------------------------------------------------
// The parser takes one octet of the element per clock cycle on the slave
// stream (tuser high marks octet 0 and resynchronizes) and emits one item per
// decoded field on the master stream: the header once octet 1 is known (at
// octet 0 for a release all), then every optional field that the header
// flags announce, the last one with tlast set. An octet is decoded in the
// cycle it is accepted and the result lands in the output register, so the
// sustained rate is one octet per cycle while the output does not stall; the
// output register takes a new result in the same cycle that its waiting item
// leaves, and a stalled, full output register holds the input back, even for
// octets that would produce no item. Octets that complete no field (octet 0
// but for a release all, the high octet of a two-octet field) give no item.
// Registers: 0x0 wide subslot numbering (start subslots take two octets), 0x4
// channel_min, 0x8 channel_max; write them only while no element is in flight.
// ----------------------------------------------------------------------------
module resource_allocation_ie_parser
    import rai_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    // octet input
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,      // in_byte[7:0]
    input  logic        i_s_tuser,      // ie_start[0]

    // decoded field output
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,      // field_value[15:0], status[17:16], zero
    output logic [3:0]  o_m_tuser,      // field_kind[3:0]
    output logic        o_m_tlast,      // last

    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration registers
    logic                 r_wide;
    logic [CHANNEL_W-1:0] r_ch_min;
    logic [CHANNEL_W-1:0] r_ch_max;

    // parser state
    logic [3:0] r_phase, n_phase;
    logic [7:0] r_header, n_header;
    logic [1:0] r_flags, n_flags;
    logic       r_hi_pend, n_hi_pend;
    logic [7:0] r_partial, n_partial;
    logic       r_invalid, n_invalid;

    // output register
    logic        r_out_valid;
    t_field_kind r_kind, n_kind;
    logic [15:0] r_value, n_value;
    t_status     r_status, n_status;
    logic        r_last, n_last;
    logic        n_emit;

    logic       w_in_acc;
    logic       w_out_acc;
    logic       w_cfg_wr;
    t_reg_idx   w_reg;
    logic [3:0] w_kind;
    logic [3:0] w_next;
    logic       w_two;
    logic [15:0] w_val;

    // is field kind k announced by the header and octet 1 flags
    function automatic logic kind_present(input logic [3:0] k, input logic [7:0] h,
                                          input logic [1:0] f);
        logic p;
        case (k)
            KIND_DL_START, KIND_DL_LEN: p = h[6];
            KIND_UL_START, KIND_UL_LEN: p = h[7];
            KIND_SHORT_ID:              p = h[4];
            KIND_REP, KIND_VALIDITY:    p = (h[3:1] != 3'd0);
            KIND_SFN:                   p = h[0];
            KIND_CHANNEL:               p = f[1];
            KIND_FAILURE:               p = f[0];
            default:                    p = 1'b0;
        endcase
        return p;
    endfunction

    // first announced kind after k, zero when the element ends
    function automatic logic [3:0] next_kind(input logic [3:0] k, input logic [7:0] h,
                                             input logic [1:0] f);
        logic [3:0] n;
        logic [3:0] c;
        n = 4'd0;
        for (int i = KIND_FAILURE; i >= KIND_DL_START; i--) begin
            c = 4'(i);
            if (c > k && kind_present(c, h, f)) begin
                n = c;
            end
        end
        return n;
    endfunction

    // handshakes
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_out_acc  = r_out_valid && i_m_tready;
    assign o_s_tready = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_kind;
    assign o_m_tlast  = r_last;
    assign o_m_tdata  = {{(OUT_TDATA_W - OUT_STATUS_LSB - 2){1'b0}}, r_status, r_value};

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_reg    = t_reg_idx'(paddr[3:2]);

    always_comb begin
        case (w_reg)
            REG_WIDE_SUBSLOT: prdata = {31'd0, r_wide};
            REG_CHANNEL_MIN:  prdata = {{(32 - CHANNEL_W){1'b0}}, r_ch_min};
            REG_CHANNEL_MAX:  prdata = {{(32 - CHANNEL_W){1'b0}}, r_ch_max};
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide   <= 1'b0;
            r_ch_min <= '0;
            r_ch_max <= '1;
        end else if (w_cfg_wr) begin
            case (w_reg)
                REG_WIDE_SUBSLOT: r_wide   <= pwdata[0];
                REG_CHANNEL_MIN:  r_ch_min <= pwdata[CHANNEL_W-1:0];
                REG_CHANNEL_MAX:  r_ch_max <= pwdata[CHANNEL_W-1:0];
                default: ;
            endcase
        end
    end

    // kind of the field being collected
    assign w_kind = r_phase - 4'd1;
    assign w_two  = (w_kind == KIND_SHORT_ID) || (w_kind == KIND_CHANNEL) ||
                    (((w_kind == KIND_DL_START) || (w_kind == KIND_UL_START)) && r_wide);
    assign w_val  = r_hi_pend ? {r_partial, i_s_tdata} : {8'd0, i_s_tdata};

    // decode of one octet
    always_comb begin
        n_phase   = r_phase;
        n_header  = r_header;
        n_flags   = r_flags;
        n_hi_pend = r_hi_pend;
        n_partial = r_partial;
        n_invalid = r_invalid;
        n_emit    = 1'b0;
        n_kind    = KIND_HEADER;
        n_value   = 16'd0;
        n_status  = STAT_OK;
        n_last    = 1'b0;
        w_next    = 4'd0;

        if (i_s_tuser || r_phase == PHASE_IDLE) begin
            // octet 0, a new element
            n_header  = i_s_tdata;
            n_flags   = 2'd0;
            n_hi_pend = 1'b0;
            n_partial = 8'd0;
            n_invalid = 1'b0;
            if (i_s_tdata[7:6] == 2'd0) begin
                // release all: header alone ends the element
                n_phase = PHASE_IDLE;
                n_emit  = 1'b1;
                n_value = {8'd0, i_s_tdata};
                n_last  = 1'b1;
            end else begin
                n_phase = PHASE_SECOND;
            end
        end else if (r_phase == PHASE_SECOND) begin
            // octet 1 completes the header
            n_flags = i_s_tdata[7:6];
            n_emit  = 1'b1;
            n_value = {6'd0, i_s_tdata[7:6], r_header};
            if (r_header[3:1] > REPEAT_MAX) begin
                n_phase  = PHASE_IDLE;
                n_status = STAT_RESERVED;
                n_last   = 1'b1;
            end else begin
                w_next  = next_kind(KIND_HEADER, r_header, i_s_tdata[7:6]);
                n_phase = (w_next == 4'd0) ? PHASE_IDLE : w_next + 4'd1;
                n_last  = (w_next == 4'd0);
            end
        end else if (!(r_phase inside {[PHASE_FIRST_FLD:PHASE_LAST_FLD]})) begin
            // unused phase codes drop back to idle
            n_phase   = PHASE_IDLE;
            n_hi_pend = 1'b0;
        end else if (!r_hi_pend && w_two) begin
            // high octet of a two-octet field
            n_partial = i_s_tdata;
            n_hi_pend = 1'b1;
        end else begin
            n_hi_pend = 1'b0;
            n_emit    = 1'b1;
            n_kind    = t_field_kind'(w_kind);
            n_value   = w_val;
            if (w_kind == KIND_REP && w_val == 16'd0) begin
                n_invalid = 1'b1;
            end
            if (w_kind == KIND_CHANNEL) begin
                n_value = {{(16 - CHANNEL_W){1'b0}}, w_val[CHANNEL_W-1:0]};
                if (w_val[CHANNEL_W-1:0] < r_ch_min || w_val[CHANNEL_W-1:0] > r_ch_max) begin
                    n_invalid = 1'b1;
                end
            end
            if (w_kind == KIND_FAILURE) begin
                n_value = {{(16 - FAILURE_W){1'b0}}, w_val[FAILURE_W-1:0]};
            end
            n_status = n_invalid ? STAT_INVALID : STAT_OK;
            w_next   = next_kind(w_kind, r_header, r_flags);
            n_phase  = (w_next == 4'd0) ? PHASE_IDLE : w_next + 4'd1;
            n_last   = (w_next == 4'd0);
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PHASE_IDLE;
            r_header  <= 8'd0;
            r_flags   <= 2'd0;
            r_hi_pend <= 1'b0;
            r_partial <= 8'd0;
            r_invalid <= 1'b0;
        end else if (w_in_acc) begin
            r_phase   <= n_phase;
            r_header  <= n_header;
            r_flags   <= n_flags;
            r_hi_pend <= n_hi_pend;
            r_partial <= n_partial;
            r_invalid <= n_invalid;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_out_valid <= n_emit;
        end else if (w_out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload, loaded only with a new item
    always_ff @(posedge i_clk) begin
        if (w_in_acc && n_emit) begin
            r_kind   <= n_kind;
            r_value  <= n_value;
            r_status <= n_status;
            r_last   <= n_last;
        end
    end

endmodule

// File: hdl/rai_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rai_checker
// port-level checks of the resource allocation ie parser
// ----------------------------------------------------------------------------
module rai_checker
    import rai_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata,
    input logic [3:0]  o_m_tuser,
    input logic        o_m_tlast
);

    // stalled item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) &&
            $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("stalled output item changed");

    // input never blocked while output register is empty
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output register");

    // unused status code never shows
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[17:16] != 2'd3)
        else $error("unused status code");

    // reserved repeat code only on a final header
    a_reserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[17:16] == STAT_RESERVED |->
            o_m_tuser == KIND_HEADER && o_m_tlast)
        else $error("reserved status outside a final header");

    // release all header ends the element
    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == KIND_HEADER && o_m_tdata[7:6] == 2'd0 |-> o_m_tlast)
        else $error("release-all header without last");

endmodule

bind resource_allocation_ie_parser rai_checker u_rai_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

// File: dv/resource_allocation_ie_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resource_allocation_ie_parser_test
// self-checking bench of the octet-serial resource allocation ie parser
// ----------------------------------------------------------------------------
// Octets go in on the slave stream and decoded fields come back on the master
// stream. A behavioral decoder in the bench follows every accepted octet and
// queues the fields it expects; a monitor pops them in order as the parser
// hands them out and compares kind, value, status and last. Directed elements
// hit the field extremes and the corner cases (release all, reserved repeat
// codes, zero repetition, idle octets, resync, channel limits); random
// elements with noise and broken elements follow under several register
// settings, with random stalls on both streams.
// ----------------------------------------------------------------------------
module resource_allocation_ie_parser_test;
    import rai_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 740;
    localparam int REPORT_MAX   = 200;

    // one decoded field as the parser should return it
    typedef struct packed {
        t_field_kind kind;
        logic [15:0] value;
        t_status     status;
        logic        last;
    } t_field_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;      // in_byte[7:0]
    logic        i_s_tuser;      // ie_start[0]
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [23:0] o_m_tdata;      // field_value[15:0], status[17:16], zero
    logic [3:0]  o_m_tuser;      // field_kind[3:0]
    logic        o_m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // fields the parser still owes us, oldest first
    t_field_item field_q[$];

    int n_err    = 0;
    int n_sent   = 0;
    int n_cycles = 0;
    bit quiet    = 1'b0;     // no idling on either stream while set

    // decoder state, mirrors the parser
    logic [3:0]  pr_phase;
    logic [7:0]  pr_hdr;
    logic [1:0]  pr_sflags;
    logic        pr_hi_pend;
    logic [7:0]  pr_part;
    logic        pr_bad;

    // register copies, reset values
    logic        cfg_wide   = 1'b0;
    logic [12:0] cfg_ch_min = 13'd0;
    logic [12:0] cfg_ch_max = 13'h1fff;

    resource_allocation_ie_parser u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver backpressure, tready low with a chance of about one in ten outside quiet stretches
    always @(negedge i_clk) begin
        i_m_tready <= quiet || ($urandom_range(99) >= 10);
    end

    // ------------------------------------------------------------------------
    // field decoder
    // ------------------------------------------------------------------------

    // does the current element carry a field of kind k
    function automatic logic field_present(input logic [3:0] k);
        case (t_field_kind'(k))
            KIND_DL_START, KIND_DL_LEN: return pr_hdr[6];
            KIND_UL_START, KIND_UL_LEN: return pr_hdr[7];
            KIND_SHORT_ID:              return pr_hdr[4];
            KIND_REP, KIND_VALIDITY:    return pr_hdr[3:1] != 3'd0;
            KIND_SFN:                   return pr_hdr[0];
            KIND_CHANNEL:               return pr_sflags[1];
            KIND_FAILURE:               return pr_sflags[0];
            default:                    return 1'b0;
        endcase
    endfunction

    // next present field after k, header kind when the element is done
    function automatic logic [3:0] next_field(input logic [3:0] k);
        int n;
        for (n = k + 1; n <= KIND_FAILURE; n++) begin
            if (field_present(4'(n)))
                return 4'(n);
        end
        return KIND_HEADER;
    endfunction

    task automatic push_field(input logic [3:0] k, input logic [15:0] v,
                              input t_status s, input logic l);
        field_q.push_back('{kind: t_field_kind'(k), value: v, status: s, last: l});
    endtask

    // queue a field and move on to the next one the header announces
    task automatic emit_field(input logic [3:0] k, input logic [15:0] v,
                              input t_status s);
        logic [3:0] nk;
        nk = next_field(k);
        pr_phase = (nk == KIND_HEADER) ? PHASE_IDLE : nk + 4'd1;
        push_field(k, v, s, nk == KIND_HEADER);
    endtask

    task automatic decode_octet(input logic [7:0] b, input logic st);
        logic [3:0]  k;
        logic [15:0] v;
        logic        two;
        if (st || pr_phase == PHASE_IDLE) begin
            // octet 0, either marked or taken while idle
            pr_hdr     = b;
            pr_sflags  = 2'd0;
            pr_hi_pend = 1'b0;
            pr_part    = 8'd0;
            pr_bad     = 1'b0;
            if (b[7:6] == 2'b00) begin
                pr_phase = PHASE_IDLE;
                push_field(KIND_HEADER, {8'd0, b}, STAT_OK, 1'b1);
            end else begin
                pr_phase = PHASE_SECOND;
            end
        end else if (pr_phase == PHASE_SECOND) begin
            pr_sflags = b[7:6];
            v = {6'd0, pr_sflags, pr_hdr};
            if (pr_hdr[3:1] > REPEAT_MAX) begin
                pr_phase = PHASE_IDLE;
                push_field(KIND_HEADER, v, STAT_RESERVED, 1'b1);
            end else begin
                emit_field(KIND_HEADER, v, STAT_OK);
            end
        end else if (pr_phase < PHASE_FIRST_FLD || pr_phase > PHASE_LAST_FLD) begin
            pr_phase   = PHASE_IDLE;
            pr_hi_pend = 1'b0;
        end else begin
            k = pr_phase - 4'd1;
            two = (k == KIND_SHORT_ID) || (k == KIND_CHANNEL) ||
                  (((k == KIND_DL_START) || (k == KIND_UL_START)) && cfg_wide);
            if (!pr_hi_pend && two) begin
                pr_part    = b;
                pr_hi_pend = 1'b1;
            end else begin
                v = pr_hi_pend ? {pr_part, b} : {8'd0, b};
                pr_hi_pend = 1'b0;
                if (k == KIND_REP && v == 16'd0)
                    pr_bad = 1'b1;
                if (k == KIND_CHANNEL) begin
                    v = v & ((16'd1 << CHANNEL_W) - 16'd1);
                    if (v[12:0] < cfg_ch_min || v[12:0] > cfg_ch_max)
                        pr_bad = 1'b1;
                end
                if (k == KIND_FAILURE)
                    v = v & ((16'd1 << FAILURE_W) - 16'd1);
                emit_field(k, v, pr_bad ? STAT_INVALID : STAT_OK);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // result monitor
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_field_item want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (field_q.size() == 0) begin
                n_err++;
                if (n_err <= REPORT_MAX)
                    $display("%0t: unexpected item kind %0d value %h status %0d last %b",
                             $time, o_m_tuser, o_m_tdata[15:0],
                             o_m_tdata[OUT_STATUS_LSB +: 2], o_m_tlast);
            end else begin
                want = field_q.pop_front();
                if (o_m_tuser !== want.kind || o_m_tdata[15:0] !== want.value ||
                    o_m_tdata[OUT_STATUS_LSB +: 2] !== want.status ||
                    o_m_tlast !== want.last) begin
                    n_err++;
                    if (n_err <= REPORT_MAX)
                        $display({"%0t: item mismatch, expected kind %0d value %h ",
                                  "status %0d last %b, got kind %0d value %h ",
                                  "status %0d last %b"},
                                 $time, want.kind, want.value, want.status, want.last,
                                 o_m_tuser, o_m_tdata[15:0],
                                 o_m_tdata[OUT_STATUS_LSB +: 2], o_m_tlast);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // drivers, all entered and left at a falling edge
    // ------------------------------------------------------------------------

    // one octet on the slave stream, with an occasional gap in front
    task automatic send_octet(input logic [7:0] b, input logic st);
        if (!quiet && $urandom_range(99) < 5) begin
            i_s_tvalid = 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = b;
        i_s_tuser  = st;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        decode_octet(b, st);
        n_sent++;
        @(negedge i_clk);
    endtask

    // hold the sender until every owed field is back and the pipe is empty
    task automatic wait_drained();
        i_s_tvalid = 1'b0;
        while (field_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = 4'(idx) << 2;
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_WIDE_SUBSLOT: cfg_wide   = val[0];
            REG_CHANNEL_MIN:  cfg_ch_min = val[12:0];
            REG_CHANNEL_MAX:  cfg_ch_max = val[12:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // close any open element, let the parser go idle, then set all registers
    task automatic reconfigure(input logic wide, input logic [12:0] lo,
                               input logic [12:0] hi);
        if (pr_phase != PHASE_IDLE)
            send_octet(8'h00, 1'b1);
        wait_drained();
        write_reg(REG_WIDE_SUBSLOT, {31'd0, wide});
        write_reg(REG_CHANNEL_MIN, {19'd0, lo});
        write_reg(REG_CHANNEL_MAX, {19'd0, hi});
    endtask

    // channel word, mostly inside the configured window, top bits random
    function automatic logic [15:0] pick_channel();
        logic [15:0] ch;
        int r;
        ch = 16'($urandom);
        r  = $urandom_range(99);
        if (cfg_ch_min <= cfg_ch_max) begin
            if (r < 10)
                ch[12:0] = cfg_ch_min;
            else if (r < 20)
                ch[12:0] = cfg_ch_max;
            else if (r < 70)
                ch[12:0] = cfg_ch_min + 13'($urandom_range(cfg_ch_max - cfg_ch_min));
        end
        return ch;
    endfunction

    // one element with random content; cut_pct of them are cut short
    task automatic send_element(input int cut_pct);
        logic [7:0]  hdr;
        logic [7:0]  sec;
        logic [15:0] ch;
        logic [7:0]  body[$];
        logic        st;
        int          cut;
        int          i;
        hdr = 8'($urandom);
        if ($urandom_range(99) < 85)
            hdr[3:1] = 3'($urandom_range(4));
        if (hdr[7:6] == 2'b00 && $urandom_range(99) < 80)
            hdr[7:6] = 2'($urandom_range(3, 1));
        sec = 8'($urandom);
        if (hdr[7:6] != 2'b00) begin
            body.push_back(sec);
            if (hdr[3:1] <= REPEAT_MAX) begin
                if (hdr[6]) begin
                    if (cfg_wide)
                        body.push_back(8'($urandom));
                    body.push_back(8'($urandom));
                    body.push_back(8'($urandom));
                end
                if (hdr[7]) begin
                    if (cfg_wide)
                        body.push_back(8'($urandom));
                    body.push_back(8'($urandom));
                    body.push_back(8'($urandom));
                end
                if (hdr[4]) begin
                    body.push_back(8'($urandom));
                    body.push_back(8'($urandom));
                end
                if (hdr[3:1] != 3'd0) begin
                    body.push_back(($urandom_range(7) == 0) ? 8'd0 : 8'($urandom));
                    body.push_back(8'($urandom));
                end
                if (hdr[0])
                    body.push_back(8'($urandom));
                if (sec[7]) begin
                    ch = pick_channel();
                    body.push_back(ch[15:8]);
                    body.push_back(ch[7:0]);
                end
                if (sec[6])
                    body.push_back(8'($urandom));
            end
        end
        cut = body.size();
        if (cut > 0 && $urandom_range(99) < cut_pct)
            cut = $urandom_range(cut - 1);
        // an idle parser takes any octet as octet 0, so the mark is optional
        st = (pr_phase != PHASE_IDLE) ? 1'b1 : 1'($urandom_range(1));
        send_octet(hdr, st);
        for (i = 0; i < cut; i++)
            send_octet(body[i], 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // corner cases under reset register values
    task automatic test_directed();
        // release all, marked and as an idle octet
        send_octet(8'h00, 1'b1);
        send_octet(8'h3f, 1'b0);
        // every field present, extremes of the content, zero repetition
        send_octet(8'hf9, 1'b1);
        send_octet(8'hff, 1'b0);
        send_octet(8'hff, 1'b0);   // dl start
        send_octet(8'h00, 1'b0);   // dl length
        send_octet(8'h00, 1'b0);   // ul start
        send_octet(8'hff, 1'b0);   // ul length
        send_octet(8'hff, 1'b0);   // short id high
        send_octet(8'h00, 1'b0);   // short id low
        send_octet(8'h00, 1'b0);   // repetition zero, element goes invalid
        send_octet(8'hff, 1'b0);   // validity
        send_octet(8'h80, 1'b0);   // sfn
        send_octet(8'hff, 1'b0);   // channel high, top bits dropped
        send_octet(8'hff, 1'b0);   // channel low
        send_octet(8'hff, 1'b0);   // failure code, low nibble kept
        // reserved repeat codes end the element at the header
        send_octet(8'h4a, 1'b1);
        send_octet(8'h00, 1'b0);
        send_octet(8'h8c, 1'b1);
        send_octet(8'hc0, 1'b0);
        send_octet(8'hce, 1'b1);
        send_octet(8'h3f, 1'b0);
        // resync while a dl start is awaited
        send_octet(8'h42, 1'b1);
        send_octet(8'h40, 1'b0);
        send_octet(8'h00, 1'b1);
    endtask

    // two-octet start subslots
    task automatic test_subslot_width();
        int i;
        reconfigure(1'b1, 13'd0, 13'h1fff);
        send_octet(8'hc0, 1'b1);
        send_octet(8'h00, 1'b0);
        send_octet(8'h12, 1'b0);   // dl start high
        send_octet(8'h34, 1'b0);   // dl start low
        send_octet(8'h85, 1'b0);
        send_octet(8'hff, 1'b0);   // ul start high
        send_octet(8'hff, 1'b0);   // ul start low
        send_octet(8'h7f, 1'b0);
        for (i = 0; i < 20; i++)
            send_element(0);
        reconfigure(1'b0, 13'd0, 13'h1fff);
        for (i = 0; i < 10; i++)
            send_element(0);
    endtask

    // channel window at its edges, empty and single-valued
    task automatic test_channel_range();
        int i;
        reconfigure(1'b0, 13'h1fff, 13'h1fff);
        send_octet(8'h40, 1'b1);
        send_octet(8'h80, 1'b0);
        send_octet(8'h01, 1'b0);
        send_octet(8'h02, 1'b0);
        send_octet(8'hff, 1'b0);   // channel 8191 with top bits set, valid
        send_octet(8'hff, 1'b0);
        send_octet(8'h40, 1'b1);
        send_octet(8'hc0, 1'b0);
        send_octet(8'h03, 1'b0);
        send_octet(8'h04, 1'b0);
        send_octet(8'h1f, 1'b0);   // channel 8190, below the window
        send_octet(8'hfe, 1'b0);
        send_octet(8'h05, 1'b0);
        // minimum above maximum, nothing passes
        reconfigure(1'b1, 13'h1fff, 13'd0);
        for (i = 0; i < 20; i++)
            send_element(0);
        reconfigure(1'b0, 13'd0, 13'd0);
        for (i = 0; i < 20; i++)
            send_element(0);
    endtask

    // random elements, noise and broken elements over many settings
    task automatic test_random();
        int          p;
        int          r;
        int          n_end;
        int          n_phase_end;
        logic [12:0] lo;
        logic [12:0] hi;
        logic [12:0] tmp;
        n_end = n_sent + RANDOM_ITEMS;
        p = 0;
        while (n_sent < n_end) begin
            lo = 13'($urandom);
            hi = 13'($urandom);
            if (lo > hi) begin
                tmp = lo;
                lo  = hi;
                hi  = tmp;
            end
            case (p % 6)
                0: reconfigure(1'b0, 13'd0, 13'h1fff);
                1: reconfigure(1'b1, 13'd0, 13'h1fff);
                2: reconfigure(1'b0, lo, hi);
                3: reconfigure(1'b1, lo, hi);
                4: reconfigure(1'($urandom_range(1)), hi, lo);
                default: reconfigure(1'($urandom_range(1)), 13'($urandom), 13'($urandom));
            endcase
            // one stretch without any idling on either side
            quiet = (p == 3);
            n_phase_end = n_sent + 180;
            while (n_sent < n_phase_end && n_sent < n_end) begin
                r = $urandom_range(99);
                if (r < 85) begin
                    send_element(10);
                end else begin
                    repeat ($urandom_range(3, 1))
                        send_octet(8'($urandom), 1'($urandom_range(99) < 20));
                end
                // sender holds off until the parser has caught up
                if (p == 2 && n_sent >= n_phase_end - 90 && n_sent < n_phase_end - 80)
                    wait_drained();
            end
            quiet = 1'b0;
            p++;
        end
    endtask

    initial begin
        int k;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = 8'd0;
        i_s_tuser  = 1'b0;
        i_m_tready = 1'b1;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = 4'd0;
        pwdata     = 32'd0;
        pr_phase   = PHASE_IDLE;
        pr_hdr     = 8'd0;
        pr_sflags  = 2'd0;
        pr_hi_pend = 1'b0;
        pr_part    = 8'd0;
        pr_bad     = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        test_subslot_width();
        test_channel_range();
        test_random();

        i_s_tvalid = 1'b0;
        for (k = 0; k < 5000 && field_q.size() != 0; k++)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (field_q.size() != 0) begin
            n_err++;
            $display("%0t: %0d expected items never arrived, oldest kind %0d value %h",
                     $time, field_q.size(), field_q[0].kind, field_q[0].value);
        end
        if (n_err == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/rai_pkg.sv
hdl/resource_allocation_ie_parser.sv
hdl/rai_checker.sv
dv/resource_allocation_ie_parser_test.sv
